// ----- design/int2r_pkg.sv -----
// Package for the integer-to-radix-text block: widths, reset values,
// register indexes, queue entry type and the alphabet check. No dependencies.
`default_nettype none

package int2r_pkg;

   // Default parameter values for the top level
   localparam int MAX_RADIX_DEF  = 16;
   localparam int VALUE_BITS_DEF = 32;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_HIGH = 2'd2;

   // Fixed field widths
   localparam int RADIX_W     = 5;
   localparam int REM_W       = 4;
   localparam int CHAR_W      = 8;
   localparam int ALPHA_CHARS = 16;
   localparam int ALPHA_IDX_W = 4;
   localparam int ALPHA_W     = ALPHA_CHARS * CHAR_W;

   // Register reset values: radix 10, alphabet "0123456789"
   localparam logic [RADIX_W-1:0]    RADIX_RESET      = 5'd10;
   localparam logic [CSR_DATA_W-1:0] ALPHA_LOW_RESET  = 64'd3978425819141910832;
   localparam logic [CSR_DATA_W-1:0] ALPHA_HIGH_RESET = 64'd14648;

   // Characters
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   // Divider: quotient bits resolved per cycle
   localparam int DIV_STEPS = 8;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Head-of-queue control seen by the back end
   typedef struct packed {
      logic valid;
      logic bad;
      logic neg;
   } q_ctl_type;

   // Alphabet is usable when radix is in range and the first radix characters
   // are non-null, hold no sign and are all distinct.
   function automatic logic alpha_ok(input logic [RADIX_W-1:0] radix,
                                     input logic [ALPHA_W-1:0] alpha,
                                     input logic [RADIX_W-1:0] max_radix);
      logic ok;
      logic [CHAR_W-1:0] ca;
      ok = (radix >= RADIX_W'(2)) && (radix <= max_radix);
      for (int a = 0; a < ALPHA_CHARS; a++) begin
         ca = alpha[a*CHAR_W +: CHAR_W];
         if (RADIX_W'(a) < radix) begin
            if (ca == CHAR_NUL || ca == CHAR_PLUS || ca == CHAR_MINUS) begin
               ok = 1'b0;
            end
            for (int b = a + 1; b < ALPHA_CHARS; b++) begin
               if (RADIX_W'(b) < radix && alpha[b*CHAR_W +: CHAR_W] == ca) begin
                  ok = 1'b0;
               end
            end
         end
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

// ----- design/int2r_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module int2r_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/int2r_front.sv -----
// Front end: accept values, check the alphabet, form sign and magnitude,
// and hold them in a short queue for the back end. Uses int2r_pkg.
`default_nettype none

module int2r_front #(
   parameter int MAX_RADIX  = int2r_pkg::MAX_RADIX_DEF,
   parameter int VALUE_BITS = int2r_pkg::VALUE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [VALUE_BITS-1:0]       req_value,
   input  wire logic [int2r_pkg::RADIX_W-1:0]      radix,
   input  wire logic [int2r_pkg::ALPHA_W-1:0]      alpha,
   output int2r_pkg::q_ctl_type                    q_ctl,
   output logic [VALUE_BITS-1:0]                   q_mag,
   input  wire logic                               q_pop
);

   logic [int2r_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic [int2r_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [int2r_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic                         bad_ff [int2r_pkg::QUEUE_DEPTH];
   logic                         neg_ff [int2r_pkg::QUEUE_DEPTH];
   logic [VALUE_BITS-1:0]        mag_ff [int2r_pkg::QUEUE_DEPTH];

   logic                  push;
   logic                  pop;
   logic [VALUE_BITS-1:0] val_u;
   logic                  neg;
   logic [VALUE_BITS-1:0] mag;
   logic                  bad;

   assign req_stall = (cnt_ff == int2r_pkg::QCNT_W'(int2r_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (cnt_ff != '0);

   // Classify: sign, magnitude without overflow, alphabet verdict
   assign val_u = req_value;
   assign neg   = val_u[VALUE_BITS-1];
   assign mag   = neg ? (~val_u + VALUE_BITS'(1)) : val_u;
   assign bad   = !int2r_pkg::alpha_ok(radix, alpha,
                                       int2r_pkg::RADIX_W'(MAX_RADIX));

   always_comb begin
      cnt_in    = cnt_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         bad_ff[wr_ptr_ff] <= bad;
         neg_ff[wr_ptr_ff] <= neg;
         mag_ff[wr_ptr_ff] <= mag;
      end
   end

   assign q_ctl.valid = (cnt_ff != '0);
   assign q_ctl.bad   = bad_ff[rd_ptr_ff];
   assign q_ctl.neg   = neg_ff[rd_ptr_ff];
   assign q_mag       = mag_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- design/int2r_back.sv -----
// Back end: repeated division by the radix into the digit RAM, then
// emission of sign and digits through the output register.
// Uses int2r_pkg and int2r_ram.
`default_nettype none

module int2r_back #(
   parameter int MAX_RADIX  = int2r_pkg::MAX_RADIX_DEF,
   parameter int VALUE_BITS = int2r_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire int2r_pkg::q_ctl_type                q_ctl,
   input  wire logic [VALUE_BITS-1:0]               q_mag,
   output logic                                     q_pop,
   input  wire logic [int2r_pkg::RADIX_W-1:0]       radix,
   input  wire logic [int2r_pkg::ALPHA_W-1:0]       alpha,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [int2r_pkg::CHAR_W-1:0]             rsp_text_char,
   output logic                                     rsp_last_char,
   output logic                                     rsp_bad_alphabet
);

   localparam int CHUNKS = (VALUE_BITS + int2r_pkg::DIV_STEPS - 1) / int2r_pkg::DIV_STEPS;
   localparam int PAD_W   = CHUNKS * int2r_pkg::DIV_STEPS;
   localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int DIG_W   = $clog2(MAX_RADIX);
   localparam int ADDR_W  = $clog2(VALUE_BITS);
   localparam int CNT_W   = $clog2(VALUE_BITS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_BAD  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_RD   = 3'd4;
   localparam logic [2:0] ST_LOAD = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [PAD_W-1:0]              dvd_ff, dvd_in;
   logic [int2r_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [CHUNK_W-1:0]            chunk_ff, chunk_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [ADDR_W-1:0]             idx_ff, idx_in;
   logic                          neg_ff, neg_in;

   logic                          out_valid_ff, out_valid_in;
   logic [int2r_pkg::CHAR_W-1:0]  out_char_ff, out_char_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_bad_ff, out_bad_in;

   logic [PAD_W-1:0]              div_dvd;
   logic [int2r_pkg::REM_W-1:0]   div_rem;
   logic [int2r_pkg::REM_W:0]     div_r2;
   logic                          div_q;
   logic                          out_free;

   logic                          ram_we;
   logic                          ram_re;
   logic [ADDR_W-1:0]             ram_raddr;
   logic [DIG_W-1:0]              ram_rdata;
   logic [int2r_pkg::ALPHA_IDX_W-1:0] char_idx;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign char_idx = int2r_pkg::ALPHA_IDX_W'(ram_rdata);

   // One chunk of restoring division: resolve DIV_STEPS quotient bits,
   // shifting them in at the bottom while the dividend leaves at the top.
   always_comb begin
      div_dvd = dvd_ff;
      div_rem = rem_ff;
      div_r2  = '0;
      div_q   = 1'b0;
      for (int i = 0; i < int2r_pkg::DIV_STEPS; i++) begin
         div_r2  = {div_rem, div_dvd[PAD_W-1]};
         div_q   = (div_r2 >= radix);
         div_rem = div_q ? int2r_pkg::REM_W'(div_r2 - radix)
                         : div_r2[int2r_pkg::REM_W-1:0];
         div_dvd = {div_dvd[PAD_W-2:0], div_q};
      end
   end

   always_comb begin
      state_in     = state_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_ctl.valid) begin
               q_pop = 1'b1;
               if (q_ctl.bad) begin
                  state_in = ST_BAD;
               end else begin
                  dvd_in   = PAD_W'(q_mag);
                  neg_in   = q_ctl.neg;
                  rem_in   = '0;
                  chunk_in = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_BAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = int2r_pkg::CHAR_NUL;
               out_last_in  = 1'b1;
               out_bad_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            dvd_in   = div_dvd;
            rem_in   = div_rem;
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CHUNK_W'(CHUNKS - 1)) begin
               // Digit done: store it, then divide the quotient again or emit
               ram_we   = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               idx_in   = cnt_ff[ADDR_W-1:0];
               rem_in   = '0;
               chunk_in = '0;
               if (div_dvd == '0 || cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
                  state_in = neg_ff ? ST_SIGN : ST_RD;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = int2r_pkg::CHAR_MINUS;
               out_last_in  = 1'b0;
               out_bad_in   = 1'b0;
               state_in     = ST_RD;
            end
         end
         ST_RD: begin
            ram_re   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // Read data holds until the next read, so wait here on a stall
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = alpha[char_idx*int2r_pkg::CHAR_W +: int2r_pkg::CHAR_W];
               out_last_in  = (idx_ff == '0);
               out_bad_in   = 1'b0;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff - 1'b1;
                  idx_in    = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      chunk_ff    <= chunk_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   int2r_ram #(
      .WIDTH (DIG_W),
      .DEPTH (VALUE_BITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (div_rem[DIG_W-1:0]),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_text_char    = out_char_ff;
   assign rsp_last_char    = out_last_ff;
   assign rsp_bad_alphabet = out_bad_ff;

endmodule

`default_nettype wire

// ----- design/int_to_radix_digits.sv -----
// Signed integer to text in a configurable radix (2 to MAX_RADIX).
// Each accepted value yields its characters one transfer at a time: a '-'
// for negative values, then the digits most significant first, the final
// one with last_char set. Zero gives one digit; the most negative value
// converts exactly. If the alphabet (radix register plus up to 16 one-byte
// characters) is too short or long, holds a null, '+' or '-', or repeats a
// character, the value yields a single transfer with text_char 0,
// last_char 1 and bad_alphabet 1. The divider resolves 8 quotient bits
// per cycle and divides the whole magnitude again for each digit; after
// the queue, pop and digit read steps, the characters go out one per
// cycle while rsp_stall is low. A two-entry queue lets new values enter
// while the back end is busy. Write the configuration registers only
// while the block is idle.
// Depends on int2r_pkg, int2r_front, int2r_back, int2r_ram.
`default_nettype none

module int_to_radix_digits #(
   parameter int MAX_RADIX  = int2r_pkg::MAX_RADIX_DEF,
   parameter int VALUE_BITS = int2r_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Register write port
   input  wire logic                                csr_wr_en,
   input  wire logic [int2r_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [int2r_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Input values
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [VALUE_BITS-1:0]        req_value,
   // Output characters
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [int2r_pkg::CHAR_W-1:0]             rsp_text_char,
   output logic                                     rsp_last_char,
   output logic                                     rsp_bad_alphabet
);

   logic [int2r_pkg::RADIX_W-1:0]    radix_ff;
   logic [int2r_pkg::CSR_DATA_W-1:0] alpha_low_ff;
   logic [int2r_pkg::CSR_DATA_W-1:0] alpha_high_ff;
   logic [int2r_pkg::ALPHA_W-1:0]    alpha;

   int2r_pkg::q_ctl_type             q_ctl;
   logic [VALUE_BITS-1:0]            q_mag;
   logic                             q_pop;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= int2r_pkg::RADIX_RESET;
         alpha_low_ff  <= int2r_pkg::ALPHA_LOW_RESET;
         alpha_high_ff <= int2r_pkg::ALPHA_HIGH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            int2r_pkg::CSR_RADIX: begin
               radix_ff <= csr_wdata[int2r_pkg::RADIX_W-1:0];
            end
            int2r_pkg::CSR_ALPHA_LOW: begin
               alpha_low_ff <= csr_wdata;
            end
            int2r_pkg::CSR_ALPHA_HIGH: begin
               alpha_high_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Character k of the alphabet sits in byte k
   assign alpha = {alpha_high_ff, alpha_low_ff};

   // Front: accept, classify and queue each value
   int2r_front #(
      .MAX_RADIX  (MAX_RADIX),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .radix     (radix_ff),
      .alpha     (alpha),
      .q_ctl     (q_ctl),
      .q_mag     (q_mag),
      .q_pop     (q_pop)
   );

   // Back: divide into digits, then emit the text
   int2r_back #(
      .MAX_RADIX  (MAX_RADIX),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_ctl            (q_ctl),
      .q_mag            (q_mag),
      .q_pop            (q_pop),
      .radix            (radix_ff),
      .alpha            (alpha),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_text_char    (rsp_text_char),
      .rsp_last_char    (rsp_last_char),
      .rsp_bad_alphabet (rsp_bad_alphabet)
   );

endmodule

`default_nettype wire
